// ----- design/asf_data_packet_parser_top_defines.svh -----
// ----------------------------------------------------------------------------
// Packet parser assertion macros
// Clocked implication checks shared by the packet parser.
// ----------------------------------------------------------------------------
`ifndef ASF_DATA_PACKET_PARSER_TOP_DEFINES_SVH
`define ASF_DATA_PACKET_PARSER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ASF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/asf_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet parser package
// Phase codes, result kinds and header constants for the packet parser.
// ----------------------------------------------------------------------------
package asf_pkg;

  typedef enum logic [4:0] {
    PH_START, PH_HDR_SKIP, PH_FLAGS, PH_SEGTYPE, PH_PLEN, PH_PAD, PH_TIME,
    PH_DUR, PH_SEGINFO, PH_STREAM, PH_SEQ, PH_OFFSET, PH_TYPE, PH_GRPSKIP,
    PH_OBJLEN, PH_TIME2, PH_LEN, PH_DATA, PH_GLEN, PH_GDATA, PH_DROP
  } phase_t;

  typedef enum logic [2:0] {
    K_PAYLOAD = 3'd0, K_REJECT = 3'd1, K_OVERRUN = 3'd2, K_GROUP = 3'd3,
    K_UNKNOWN = 3'd4
  } kind_t;

  localparam logic [7:0] SYNC_BYTE     = 8'h82;
  localparam logic [7:0] FLG_MULTI     = 8'h01;
  localparam logic [7:0] FLG_PAD_BYTE  = 8'h08;
  localparam logic [7:0] FLG_PAD_WORD  = 8'h10;
  localparam logic [7:0] FLG_EXPLICIT  = 8'h40;
  localparam logic [7:0] OFS_BYTE      = 8'h55;
  localparam logic [7:0] OFS_WORD      = 8'h59;
  localparam logic [7:0] OFS_DWORD     = 8'h5D;
  localparam logic [7:0] SEG_GROUPED   = 8'h01;
  localparam logic [7:0] SEG_SINGLE    = 8'h08;
  localparam logic [15:0] SIZE_RESET   = 16'd1024;

endpackage

// ----- design/asf_data_packet_parser_top.sv -----
// ----------------------------------------------------------------------------
// Data packet parser
// Parses fixed-size media data packets one byte per word and emits payload
// bytes tagged with their segment fields, or warning words.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one packet byte per word. out_valid/out_stall
//   carry at most one result word per input word: a payload byte with its
//   stream, sequence, offset, time, duration and first/last marks, or a
//   warning (rejected packet, length overrun, group sum mismatch, unknown
//   segment type) with all other fields zero.
//   cfg_valid/cfg_ready write packet_size; write it only while idle.
//   An accepted byte's result is registered in the output register. One byte
//   is taken every cycle while the input is not stalled; the parser state advances in
//   a single pass of short logic per byte.
//   When the receiver stalls with a result held, the input stalls only if the
//   output register is full and stalled, so the output register alone parts
//   the two sides. Reset returns to waiting for a packet start byte with
//   packet_size 1024 and no pending result.
module asf_data_packet_parser_top
  import asf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_packet_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [6:0]  out_stream_number,
  output logic [7:0]  out_sequence_res,
  output logic signed [32:0] out_fragment_offset,
  output logic [31:0] out_presentation_time,
  output logic [15:0] out_duration,
  output logic        out_first_of_payload,
  output logic        out_last_of_payload
);
`include "asf_data_packet_parser_top_defines.svh"

  phase_t      phase_r, phase_nxt;
  logic [15:0] size_r, pos_r, pos_nxt;
  logic [7:0]  flags_r, flags_nxt, ocode_r, ocode_nxt, stype_r, stype_nxt;
  logic [15:0] plen_r, plen_nxt, pad_r, pad_nxt, seg_r, seg_nxt;
  logic [5:0]  segs_r, segs_nxt;
  logic        lbyte_r, lbyte_nxt, first_r, first_nxt;
  logic [31:0] acc_r, acc_nxt, ofs_r, ofs_nxt, rtime_r, rtime_nxt;
  logic [2:0]  fleft_r, fleft_nxt, fwid_r, fwid_nxt;
  logic [6:0]  strm_r, strm_nxt;
  logic [7:0]  seq_r, seq_nxt, grp_r, grp_nxt;
  logic [15:0] dur_r, dur_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  okind_r, okind_nxt;
  logic [7:0]  obyte_r, obyte_nxt, oseq_r, oseq_nxt;
  logic [6:0]  ostrm_r, ostrm_nxt;
  logic [32:0] oofs_r, oofs_nxt;
  logic [31:0] otime_r, otime_nxt;
  logic [15:0] odur_r, odur_nxt;
  logic        ofirst_r, ofirst_nxt, olast_r, olast_nxt;

  logic take;
  assign in_stall  = ov_r & out_stall;
  assign take      = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_valid) begin
      size_r <= cfg_packet_size;
    end
  end

  // Combinational step: one byte through the parser.
  always_comb begin
    logic [7:0]  b;
    logic [16:0] pos1, rem, len17;
    logic        neg, known, emit, ewarn;
    logic [2:0]  n, wk;
    logic [1:0]  sh;
    logic [31:0] v;
    logic [7:0]  gl;
    logic [15:0] sb;
    logic        do_len, do_fd, do_end, eg, elast;
    logic [16:0] lenv;
    logic [7:0]  eb;
    b = in_data_byte;
    pos1 = {1'b0, pos_r} + 17'd1;
    rem = ({1'b0, size_r} > pos1) ? ({1'b0, size_r} - pos1) : 17'd0;
    phase_nxt = phase_r; flags_nxt = flags_r; ocode_nxt = ocode_r;
    stype_nxt = stype_r; plen_nxt = plen_r; pad_nxt = pad_r; seg_nxt = seg_r;
    segs_nxt = segs_r; lbyte_nxt = lbyte_r; first_nxt = first_r;
    acc_nxt = acc_r; ofs_nxt = ofs_r; rtime_nxt = rtime_r; fleft_nxt = fleft_r;
    fwid_nxt = fwid_r; strm_nxt = strm_r; seq_nxt = seq_r; grp_nxt = grp_r;
    dur_nxt = dur_r;
    emit = 1'b0; ewarn = 1'b0; wk = K_PAYLOAD; eb = b; eg = 1'b0; elast = 1'b0;
    do_len = 1'b0; do_fd = 1'b0; do_end = 1'b0; lenv = 17'd0; neg = 1'b0;
    n = 3'd0; sh = 2'd0; v = 32'd0; gl = 8'd0; sb = 16'd0; len17 = 17'd0;
    known = 1'b0;
    case (phase_r)
      PH_START: begin
        flags_nxt = 8'd0; ocode_nxt = 8'd0; plen_nxt = 16'd0; pad_nxt = 16'd0;
        segs_nxt = 6'd0; lbyte_nxt = 1'b0;
        if (b == SYNC_BYTE) begin
          phase_nxt = PH_HDR_SKIP; fleft_nxt = 3'd2; fwid_nxt = 3'd2; acc_nxt = '0;
        end else begin
          ewarn = 1'b1; wk = K_REJECT; phase_nxt = PH_DROP;
        end
      end
      PH_HDR_SKIP, PH_PLEN, PH_PAD, PH_TIME, PH_DUR, PH_OFFSET, PH_GRPSKIP,
      PH_OBJLEN, PH_TIME2, PH_LEN: begin
        sh = 2'(fwid_r - fleft_r);
        v = acc_r | ({24'd0, b} << {sh, 3'b000});
        acc_nxt = v;
        n = (fleft_r != 3'd0) ? fleft_r - 3'd1 : 3'd0;
        fleft_nxt = n;
        do_fd = (n == 3'd0);
      end
      PH_FLAGS: begin
        flags_nxt = b; phase_nxt = PH_SEGTYPE;
      end
      PH_SEGTYPE: begin
        ocode_nxt = b; acc_nxt = '0;
        if ((flags_r & FLG_EXPLICIT) != 0) begin
          phase_nxt = PH_PLEN; fleft_nxt = 3'd2; fwid_nxt = 3'd2;
        end else if ((flags_r & FLG_PAD_BYTE) != 0) begin
          phase_nxt = PH_PAD; fleft_nxt = 3'd1; fwid_nxt = 3'd1;
        end else if ((flags_r & FLG_PAD_WORD) != 0) begin
          phase_nxt = PH_PAD; fleft_nxt = 3'd2; fwid_nxt = 3'd2;
        end else begin
          phase_nxt = PH_TIME; fleft_nxt = 3'd4; fwid_nxt = 3'd4;
        end
      end
      PH_SEGINFO: begin
        lbyte_nxt = (b[7:6] == 2'b01); segs_nxt = b[5:0];
        phase_nxt = (b[5:0] != 6'd0) ? PH_STREAM : PH_DROP;
      end
      PH_STREAM: begin
        strm_nxt = b[6:0]; phase_nxt = PH_SEQ;
      end
      PH_SEQ: begin
        seq_nxt = b; acc_nxt = '0;
        case (ocode_r)
          OFS_BYTE:  n = 3'd1;
          OFS_WORD:  n = 3'd2;
          OFS_DWORD: n = 3'd4;
          default:   n = 3'd0;
        endcase
        if (n == 3'd0) begin
          ofs_nxt = 32'd0; phase_nxt = PH_TYPE;
        end else begin
          phase_nxt = PH_OFFSET; fleft_nxt = n; fwid_nxt = n;
        end
      end
      PH_TYPE: begin
        stype_nxt = b; acc_nxt = '0;
        if (b == SEG_GROUPED) begin
          phase_nxt = PH_GRPSKIP; fleft_nxt = 3'd1; fwid_nxt = 3'd1;
        end else if (b == SEG_SINGLE) begin
          phase_nxt = PH_OBJLEN; fleft_nxt = 3'd4; fwid_nxt = 3'd4;
        end else begin
          do_len = 1'b1;
        end
      end
      PH_DATA: begin
        if (stype_r == SEG_SINGLE) begin
          emit = 1'b1; elast = (seg_r == 16'd1);
        end
        sb = (seg_r != 16'd0) ? seg_r - 16'd1 : 16'd0;
        seg_nxt = sb;
        do_end = (sb == 16'd0);
      end
      PH_GLEN: begin
        sb = (seg_r != 16'd0) ? seg_r - 16'd1 : 16'd0;
        seg_nxt = sb;
        if ({8'd0, b} > sb) begin
          ewarn = 1'b1; wk = K_GROUP; gl = sb[7:0];
        end else begin
          gl = b;
        end
        grp_nxt = gl;
        if (gl == 8'd0) begin
          do_end = (sb == 16'd0);
        end else begin
          phase_nxt = PH_GDATA; first_nxt = 1'b1;
        end
      end
      PH_GDATA: begin
        emit = 1'b1; eg = 1'b1; elast = (grp_r == 8'd1);
        gl = (grp_r != 8'd0) ? grp_r - 8'd1 : 8'd0;
        sb = (seg_r != 16'd0) ? seg_r - 16'd1 : 16'd0;
        grp_nxt = gl; seg_nxt = sb;
        if (gl == 8'd0) begin
          if (sb == 16'd0) do_end = 1'b1;
          else phase_nxt = PH_GLEN;
        end
      end
      default: phase_nxt = PH_DROP;
    endcase

    // Completion of a multibyte field.
    if (do_fd) begin
      acc_nxt = v;
      case (phase_r)
        PH_HDR_SKIP: phase_nxt = PH_FLAGS;
        PH_PLEN: begin
          plen_nxt = v[15:0]; acc_nxt = '0;
          if ((flags_r & (FLG_PAD_BYTE | FLG_PAD_WORD)) != 0) begin
            phase_nxt = PH_PAD;
            n = ((flags_r & FLG_PAD_WORD) != 0) ? 3'd2 : 3'd1;
            fleft_nxt = n; fwid_nxt = n;
          end else begin
            phase_nxt = PH_TIME; fleft_nxt = 3'd4; fwid_nxt = 3'd4;
          end
        end
        PH_PAD: begin
          pad_nxt = v[15:0]; acc_nxt = '0;
          phase_nxt = PH_TIME; fleft_nxt = 3'd4; fwid_nxt = 3'd4;
        end
        PH_TIME: begin
          acc_nxt = '0; phase_nxt = PH_DUR; fleft_nxt = 3'd2; fwid_nxt = 3'd2;
        end
        PH_DUR: begin
          dur_nxt = v[15:0];
          if ((flags_r & FLG_MULTI) != 0) begin
            phase_nxt = PH_SEGINFO;
          end else begin
            segs_nxt = 6'd1; phase_nxt = PH_STREAM;
          end
        end
        PH_OFFSET: begin
          ofs_nxt = v; phase_nxt = PH_TYPE;
        end
        PH_GRPSKIP: do_len = 1'b1;
        PH_OBJLEN: begin
          acc_nxt = '0; phase_nxt = PH_TIME2; fleft_nxt = 3'd4; fwid_nxt = 3'd4;
        end
        PH_TIME2: begin
          rtime_nxt = v; do_len = 1'b1;
        end
        PH_LEN: begin
          lenv = {1'b0, v[15:0]};
          neg = 1'b0;
          len17 = lenv;
        end
        default: phase_nxt = PH_DROP;
      endcase
    end

    // Segment length, taken from the header or from a length field.
    if (do_len) begin
      if ((flags_r & FLG_MULTI) != 0) begin
        acc_nxt = '0; phase_nxt = PH_LEN;
        n = lbyte_r ? 3'd1 : 3'd2;
        fleft_nxt = n; fwid_nxt = n;
      end else begin
        // Implicit length: payload end minus the next position.
        lenv = ((flags_r & FLG_EXPLICIT) != 0) ? {1'b0, plen_r}
                                                : ({1'b0, size_r} - {1'b0, pad_r});
        neg = (lenv < pos1) && ((flags_r & FLG_EXPLICIT) != 0 || size_r >= pad_r);
        if ((flags_r & FLG_EXPLICIT) == 0 && size_r < pad_r) neg = 1'b1;
        len17 = lenv - pos1;
      end
    end
    if ((do_fd && phase_r == PH_LEN) ||
        (do_len && (flags_r & FLG_MULTI) == 0)) begin
      known = (stype_nxt == SEG_GROUPED) || (stype_nxt == SEG_SINGLE);
      if (!known) begin
        ewarn = 1'b1; wk = K_UNKNOWN;
      end else if (neg || len17 > rem) begin
        ewarn = 1'b1; wk = K_OVERRUN;
      end
      sb = neg ? 16'd0 : ((len17 > rem) ? rem[15:0] : len17[15:0]);
      seg_nxt = sb;
      if (sb == 16'd0) do_end = 1'b1;
      else if (stype_nxt == SEG_GROUPED) phase_nxt = PH_GLEN;
      else begin
        phase_nxt = PH_DATA; first_nxt = 1'b1;
      end
    end

    if (do_end) begin
      n = 3'd0;
      if (segs_nxt != 6'd0) segs_nxt = segs_nxt - 6'd1;
      phase_nxt = (segs_nxt != 6'd0) ? PH_STREAM : PH_DROP;
    end

    if (pos1 >= {1'b0, size_r}) begin
      phase_nxt = PH_START; pos_nxt = 16'd0;
    end else begin
      pos_nxt = pos1[15:0];
    end

    // Result word.
    ov_nxt = ov_r & out_stall;
    okind_nxt = okind_r; obyte_nxt = obyte_r; ostrm_nxt = ostrm_r; oseq_nxt = oseq_r;
    oofs_nxt = oofs_r; otime_nxt = otime_r; odur_nxt = odur_r;
    ofirst_nxt = ofirst_r; olast_nxt = olast_r;
    if (ewarn || emit) begin
      ov_nxt = 1'b1;
      okind_nxt = ewarn ? wk : K_PAYLOAD;
      obyte_nxt = '0; ostrm_nxt = '0; oseq_nxt = '0; oofs_nxt = '0; otime_nxt = '0;
      odur_nxt = '0; ofirst_nxt = 1'b0; olast_nxt = 1'b0;
      if (emit) begin
        obyte_nxt = eb; ostrm_nxt = strm_r; oseq_nxt = seq_r;
        oofs_nxt = eg ? {33{1'b1}} : {1'b0, ofs_r};
        otime_nxt = eg ? ofs_r : rtime_r;
        odur_nxt = dur_r; ofirst_nxt = first_r; olast_nxt = elast;
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START; pos_r <= '0; flags_r <= '0; ocode_r <= '0;
      stype_r <= '0; plen_r <= '0; pad_r <= '0; seg_r <= '0; segs_r <= '0;
      lbyte_r <= 1'b0; first_r <= 1'b0; acc_r <= '0; ofs_r <= '0; rtime_r <= '0;
      fleft_r <= '0; fwid_r <= '0; strm_r <= '0; seq_r <= '0; grp_r <= '0;
      dur_r <= '0; ov_r <= 1'b0;
    end else begin
      ov_r <= take ? ov_nxt : (ov_r & out_stall);
      if (take) begin
        phase_r <= phase_nxt; pos_r <= pos_nxt; flags_r <= flags_nxt;
        ocode_r <= ocode_nxt; stype_r <= stype_nxt; plen_r <= plen_nxt;
        pad_r <= pad_nxt; seg_r <= seg_nxt; segs_r <= segs_nxt; lbyte_r <= lbyte_nxt;
        first_r <= first_nxt; acc_r <= acc_nxt; ofs_r <= ofs_nxt; rtime_r <= rtime_nxt;
        fleft_r <= fleft_nxt; fwid_r <= fwid_nxt; strm_r <= strm_nxt; seq_r <= seq_nxt;
        grp_r <= grp_nxt; dur_r <= dur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      okind_r <= okind_nxt; obyte_r <= obyte_nxt; ostrm_r <= ostrm_nxt;
      oseq_r <= oseq_nxt; oofs_r <= oofs_nxt; otime_r <= otime_nxt;
      odur_r <= odur_nxt; ofirst_r <= ofirst_nxt; olast_r <= olast_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_payload_byte = obyte_r;
  assign out_stream_number = ostrm_r;
  assign out_sequence_res = oseq_r;
  assign out_fragment_offset = oofs_r;
  assign out_presentation_time = otime_r;
  assign out_duration = odur_r;
  assign out_first_of_payload = ofirst_r;
  assign out_last_of_payload = olast_r;

  `ASF_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_kind),
    "result word lost while stalled")
  `ASF_ASSERT_IMPL(a_pos, 1'b1, pos_r < size_r || pos_r == 16'd0 || size_r < 16'd2,
    "byte position past packet end")
  `ASF_ASSERT_IMPL(a_warn, out_valid && out_kind != K_PAYLOAD,
    !out_first_of_payload && !out_last_of_payload && out_payload_byte == 8'd0,
    "warning word carries payload fields")

endmodule
